// File: design/pwsc_pkg.sv
// Shared types and constants of the phase-weighted support centroid.
package pwsc_pkg;

    localparam int Q15_W      = 16;
    localparam int PHASE_W    = 17;
    localparam int FOOT_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RAMP_STEPS = 15;

    localparam logic [Q15_W-1:0] ONE_Q15 = 16'h8000;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MIN_WEIGHT   = 3'd0;
    localparam t_cfg_idx CFG_STANCE_START = 3'd1;
    localparam t_cfg_idx CFG_SWING_START  = 3'd2;
    localparam t_cfg_idx CFG_HEADING_OFS  = 3'd3;
    localparam t_cfg_idx CFG_LATERAL_OFS  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch an accepted leg word
        logic ramp_div;   // start ramp division
        logic ramp_set;   // ramp from the end cases, no division
        logic ramp_take;  // ramp from divider quotient
        logic mul_wgt;
        logic take_wgt;
        logic mul_x;      // also accumulates weight and plain sums
        logic acc_x;      // also multiplies y
        logic acc_y;
        logic div_x;
        logic div_y;
        logic take_x;
        logic take_y;     // load output word, clear sums
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic closing;
    } t_dp_sts;

endpackage

// File: design/phase_weighted_support_centroid.sv
// Phase-weighted support centroid: stream ports, config port, controller and datapath.
// A leg word runs through the ramp, weight and sum steps, with a 15-step divide when its ramp needs one.
// A closing leg adds the two centroid divisions on the shared bit-serial divider.
// One leg word at a time; the next is taken while a finished result waits on the master side.
// Synchronous active-low reset clears config registers, sums, leg count and output valid.
module phase_weighted_support_centroid
    import pwsc_pkg::*;
#(
    parameter int MAX_LEGS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side: one leg word
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [103:0]          i_s_tdata,   // stance_phase[16:0], swing_phase[33:17],
                                               // foot_x[65:34], foot_y[97:66], zero pad
    input  logic                  i_s_tuser,   // leg_grounded
    input  logic                  i_s_tlast,   // last_leg
    // master side: centroid target
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [63:0]           o_m_tdata,   // target_x[31:0], target_y[63:32]
    output logic                  o_m_tuser,   // used_plain_mean
    // config writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [FOOT_W-1:0] target_x;
    logic [FOOT_W-1:0] target_y;

    assign o_cfg_ready = 1'b1;

    pwsc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    pwsc_dp #(
        .MAX_LEGS(MAX_LEGS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_leg_grounded   (i_s_tuser),
        .i_stance_phase   (i_s_tdata[16:0]),
        .i_swing_phase    (i_s_tdata[33:17]),
        .i_foot_x         (i_s_tdata[65:34]),
        .i_foot_y         (i_s_tdata[97:66]),
        .i_last_leg       (i_s_tlast),
        .o_target_x       (target_x),
        .o_target_y       (target_y),
        .o_used_plain_mean(o_m_tuser)
    );

    assign o_m_tdata = {target_y, target_x};

endmodule

// File: design/pwsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pwsc_div
    import pwsc_pkg::*;
#(
    parameter int NUM_W  = 52,
    parameter int DEN_W  = 18,
    parameter int STEP_W = $clog2(NUM_W + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEN_W-1:0]  i_rem_init,
    input  logic [NUM_W-1:0]  i_dividend,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_busy,
    output logic [NUM_W-1:0]  o_quo
);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_dq;

    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W:0]    diff;
    logic [DEN_W-1:0]  n_rem;

    assign trial = {r_rem, r_dq[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};
    assign n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_dq   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
            r_rem  <= i_rem_init;
            r_dq   <= i_dividend;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[NUM_W-2:0], ge};
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_dq;

    a_quo_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy && !i_start |=> $stable(o_quo))
        else $error("divider quotient changed while idle");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && $past(r_busy) |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_cnt == STEP_W'(1) |=> !r_busy)
        else $error("divider ran past its step count");

endmodule

// File: design/pwsc_dp.sv
// Datapath: config registers, weight ramp, shared multiplier, sums, divider and output word.
module pwsc_dp
    import pwsc_pkg::*;
#(
    parameter int MAX_LEGS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_leg_grounded,
    input  logic [PHASE_W-1:0]    i_stance_phase,
    input  logic [PHASE_W-1:0]    i_swing_phase,
    input  logic [FOOT_W-1:0]     i_foot_x,
    input  logic [FOOT_W-1:0]     i_foot_y,
    input  logic                  i_last_leg,
    output logic [FOOT_W-1:0]     o_target_x,
    output logic [FOOT_W-1:0]     o_target_y,
    output logic                  o_used_plain_mean
);

    localparam int CNT_W  = $clog2(MAX_LEGS + 1);
    localparam int WSUM_W = $clog2(MAX_LEGS * 32768 + 1);
    localparam int WX_W   = 50 + $clog2(MAX_LEGS + 1);
    localparam int PS_W   = FOOT_W + 1 + $clog2(MAX_LEGS + 1);
    localparam int PROD_W = 50;
    localparam int RES_W  = WX_W + 2;
    localparam int STEP_W = $clog2(WX_W + 1);

    function automatic logic [Q15_W-1:0] phase_clamp(input logic [PHASE_W-1:0] p);
        logic [Q15_W-1:0] v;
        v = p[Q15_W-1:0];
        if (p[PHASE_W-1]) begin
            return '0;
        end
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    function automatic logic [FOOT_W-1:0] sat32(input logic [RES_W-1:0] v);
        logic [RES_W-FOOT_W:0] upper;
        upper = v[RES_W-1:FOOT_W-1];
        if (&upper || ~|upper) begin
            return v[FOOT_W-1:0];
        end
        return v[RES_W-1] ? {1'b1, {(FOOT_W-1){1'b0}}} : {1'b0, {(FOOT_W-1){1'b1}}};
    endfunction

    // config
    logic [Q15_W-1:0]  r_min_w;
    logic [Q15_W-1:0]  r_stance_start;
    logic [Q15_W-1:0]  r_swing_start;
    logic [FOOT_W-1:0] r_heading;
    logic [FOOT_W-1:0] r_lateral;
    logic [Q15_W-1:0]  cfg_q15;

    assign cfg_q15 = (i_cfg_data[Q15_W-1:0] > ONE_Q15) ? ONE_Q15 : i_cfg_data[Q15_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_w        <= '0;
            r_stance_start <= '0;
            r_swing_start  <= '0;
            r_heading      <= '0;
            r_lateral      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_WEIGHT:   r_min_w        <= cfg_q15;
                CFG_STANCE_START: r_stance_start <= cfg_q15;
                CFG_SWING_START:  r_swing_start  <= cfg_q15;
                CFG_HEADING_OFS:  r_heading      <= i_cfg_data;
                CFG_LATERAL_OFS:  r_lateral      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // leg word
    logic              r_grounded;
    logic              r_last;
    logic [Q15_W-1:0]  r_phase;
    logic [Q15_W-1:0]  r_start;
    logic [FOOT_W-1:0] r_fx;
    logic [FOOT_W-1:0] r_fy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_grounded <= i_leg_grounded;
            r_last     <= i_last_leg;
            r_phase    <= i_leg_grounded ? phase_clamp(i_stance_phase)
                                         : phase_clamp(i_swing_phase);
            r_start    <= i_leg_grounded ? r_stance_start : r_swing_start;
            r_fx       <= i_foot_x;
            r_fy       <= i_foot_y;
        end
    end

    // ramp and weight
    logic [Q15_W-1:0] r_ramp;
    logic [Q15_W-1:0] r_w;
    logic [Q15_W-1:0] ramp_end;
    logic [Q15_W-1:0] r_eff;
    logic [Q15_W-1:0] one_minus_min;
    logic             need_div;

    assign need_div = (r_start != ONE_Q15) && (r_phase > r_start) && (r_phase != ONE_Q15);
    always_comb begin
        if (r_start == ONE_Q15) begin
            ramp_end = (r_phase == ONE_Q15) ? ONE_Q15 : '0;
        end else begin
            ramp_end = (r_phase <= r_start) ? '0 : ONE_Q15;
        end
    end
    assign r_eff         = r_grounded ? ONE_Q15 - r_ramp : r_ramp;
    assign one_minus_min = ONE_Q15 - r_min_w;

    // shared multiplier, product registered
    logic signed [FOOT_W:0]   mul_a;
    logic signed [Q15_W:0]    mul_b;
    logic signed [PROD_W-1:0] r_prod;

    always_comb begin
        mul_a = $signed({{(FOOT_W-Q15_W+1){1'b0}}, one_minus_min});
        mul_b = $signed({1'b0, r_eff});
        if (i_cmd.mul_x) begin
            mul_a = $signed({r_fx[FOOT_W-1], r_fx});
            mul_b = $signed({1'b0, r_w});
        end else if (i_cmd.acc_x) begin
            mul_a = $signed({r_fy[FOOT_W-1], r_fy});
            mul_b = $signed({1'b0, r_w});
        end
    end

    // divider
    logic [WX_W-1:0] quo;
    logic            div_busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_wgt || i_cmd.mul_x || i_cmd.acc_x) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.ramp_set) begin
            r_ramp <= ramp_end;
        end else if (i_cmd.ramp_take) begin
            r_ramp <= {1'b0, quo[RAMP_STEPS-1:0]};
        end
        if (i_cmd.take_wgt) begin
            r_w <= r_min_w + r_prod[2*RAMP_STEPS:RAMP_STEPS];
        end
    end

    // sums
    logic        [WSUM_W-1:0] r_wsum;
    logic signed [WX_W-1:0]   r_wx;
    logic signed [WX_W-1:0]   r_wy;
    logic signed [PS_W-1:0]   r_px;
    logic signed [PS_W-1:0]   r_py;
    logic        [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.take_y) begin
            r_wsum  <= '0;
            r_wx    <= '0;
            r_wy    <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.mul_x) begin
                r_wsum  <= r_wsum + WSUM_W'(r_w);
                r_px    <= r_px + PS_W'($signed(r_fx));
                r_py    <= r_py + PS_W'($signed(r_fy));
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.acc_x) begin
                r_wx <= r_wx + WX_W'(r_prod);
            end
            if (i_cmd.acc_y) begin
                r_wy <= r_wy + WX_W'(r_prod);
            end
        end
    end

    // final division operands: sign and magnitude, rounding half added up front
    logic                     plain;
    logic        [WSUM_W-1:0] den_fin;
    logic signed [WX_W-1:0]   num_sel;
    logic                     num_neg;
    logic        [WX_W-1:0]   num_mag;
    logic                     div_start;
    logic        [WSUM_W-1:0] div_rem_init;
    logic        [WX_W-1:0]   div_dividend;
    logic        [WSUM_W-1:0] div_den;
    logic        [STEP_W-1:0] div_steps;

    assign plain   = (r_wsum == '0);
    assign den_fin = plain ? WSUM_W'(r_count) : r_wsum;

    always_comb begin
        if (i_cmd.div_y || i_cmd.take_y) begin
            num_sel = plain ? WX_W'(r_py) : r_wy;
        end else begin
            num_sel = plain ? WX_W'(r_px) : r_wx;
        end
    end
    assign num_neg = num_sel[WX_W-1];
    assign num_mag = num_neg ? WX_W'(-num_sel) : WX_W'(num_sel);

    assign div_start = i_cmd.ramp_div || i_cmd.div_x || i_cmd.div_y;
    always_comb begin
        if (i_cmd.ramp_div) begin
            div_rem_init = WSUM_W'(r_phase - r_start);
            div_dividend = '0;
            div_den      = WSUM_W'(ONE_Q15 - r_start);
            div_steps    = STEP_W'(RAMP_STEPS);
        end else begin
            div_rem_init = '0;
            div_dividend = num_mag + WX_W'(den_fin >> 1);
            div_den      = den_fin;
            div_steps    = STEP_W'(WX_W);
        end
    end

    pwsc_div #(
        .NUM_W (WX_W),
        .DEN_W (WSUM_W),
        .STEP_W(STEP_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rem_init(div_rem_init),
        .i_dividend(div_dividend),
        .i_den     (div_den),
        .i_steps   (div_steps),
        .o_busy    (div_busy),
        .o_quo     (quo)
    );

    // result: signed quotient plus offset, saturated
    logic                    r_neg;   // sign of the dividend now in the divider
    logic signed [RES_W-1:0] q_signed;
    logic signed [RES_W-1:0] res;
    logic        [FOOT_W-1:0] ofs;
    logic        [FOOT_W-1:0] r_cx;

    assign ofs      = (i_cmd.take_y) ? r_lateral : r_heading;
    assign q_signed = r_neg ? -$signed(RES_W'(quo)) : $signed(RES_W'(quo));
    assign res      = q_signed + RES_W'($signed(ofs));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_x || i_cmd.div_y) begin
            r_neg <= num_neg;
        end
        if (i_cmd.take_x) begin
            r_cx <= sat32(res);
        end
        if (i_cmd.take_y) begin
            o_target_x        <= r_cx;
            o_target_y        <= sat32(res);
            o_used_plain_mean <= plain;
        end
    end

    assign o_sts.need_div = need_div;
    assign o_sts.div_busy = div_busy;
    assign o_sts.closing  = r_last || (r_count == CNT_W'(MAX_LEGS));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEGS))
        else $error("leg count beyond MAX_LEGS");

    a_weight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_x |-> r_w <= ONE_Q15 && r_w >= r_min_w)
        else $error("leg weight outside min..1.0");

    a_ramp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_wgt |-> r_ramp <= ONE_Q15)
        else $error("ramp above 1.0");

endmodule

// File: design/pwsc_ctrl.sv
// Controller: sequences each leg word and the closing divisions, owns the output valid.
module pwsc_ctrl
    import pwsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_m_tready,
    output logic    o_m_tvalid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAMP,
        ST_RDIV,
        ST_WMUL,
        ST_WGT,
        ST_XMUL,
        ST_XACC,
        ST_YACC,
        ST_DIVX,
        ST_WX,
        ST_WY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid) n_state = ST_RAMP;
            end
            ST_RAMP: begin
                if (i_sts.need_div) begin
                    o_cmd.ramp_div = 1'b1;
                    n_state        = ST_RDIV;
                end else begin
                    o_cmd.ramp_set = 1'b1;
                    n_state        = ST_WMUL;
                end
            end
            ST_RDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.ramp_take = 1'b1;
                    n_state         = ST_WMUL;
                end
            end
            ST_WMUL: begin
                o_cmd.mul_wgt = 1'b1;
                n_state       = ST_WGT;
            end
            ST_WGT: begin
                o_cmd.take_wgt = 1'b1;
                n_state        = ST_XMUL;
            end
            ST_XMUL: begin
                o_cmd.mul_x = 1'b1;
                n_state     = ST_XACC;
            end
            ST_XACC: begin
                o_cmd.acc_x = 1'b1;
                n_state     = ST_YACC;
            end
            ST_YACC: begin
                o_cmd.acc_y = 1'b1;
                n_state     = i_sts.closing ? ST_DIVX : ST_IDLE;
            end
            ST_DIVX: begin
                o_cmd.div_x = 1'b1;
                n_state     = ST_WX;
            end
            ST_WX: begin
                if (!i_sts.div_busy) begin
                    o_cmd.take_x = 1'b1;
                    o_cmd.div_y  = 1'b1;
                    n_state      = ST_WY;
                end
            end
            ST_WY: begin
                // hold the y quotient until the output register is free
                if (!i_sts.div_busy && slot_free) begin
                    o_cmd.take_y = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.take_y) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_y |-> slot_free)
        else $error("output word overwritten before it was taken");

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ramp_div || o_cmd.div_x || o_cmd.div_y) |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_close_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_YACC && i_sts.closing |=> r_state == ST_DIVX)
        else $error("closing leg did not start the centroid division");

endmodule
